// File: sv/svp_pkg.sv
// Shared types and constants of the spin velocity profile generator.
package svp_pkg;

    // Fixed field widths
    localparam int unsigned DT_W    = 16;
    localparam int unsigned LIM_W   = 24;
    localparam int unsigned HIN_W   = 19;
    localparam int unsigned HOUT_W  = 20;
    localparam int unsigned RATE_W  = 25;
    localparam int unsigned UNIT_W  = 64;

    // Angle constants, Q.16 radians
    localparam logic signed [19:0] PI_Q     = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_Q = 20'sd411775;

    // Rate saturation limits, signed Q8.16
    localparam logic signed [24:0] RATE_MAX = 25'sh0FF_FFFF;
    localparam logic signed [24:0] RATE_MIN = 25'sh100_0000;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [1:0] CFG_MAX_ACCEL  = 2'd1;
    localparam logic [1:0] CFG_MAX_RATE   = 2'd2;

    // Input item kinds
    localparam logic MODE_START = 1'b0;

    // Profile phase of the running move
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_REST,
        PH_UP,
        PH_CRUISE,
        PH_DOWN,
        PH_FINAL
    } t_phase;

    // Sequencer states
    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_WAIT,
        SQ_PA,
        SQ_WW,
        SQ_PICK,
        SQ_T_ADT,
        SQ_T_DEN,
        SQ_T_DIV,
        SQ_T_SQRT,
        SQ_T_END,
        SQ_R_ADT,
        SQ_R_DIV,
        SQ_R_RND,
        SQ_R_AW,
        SQ_R_AWDT,
        SQ_R_CDIV,
        SQ_R_END,
        SQ_TICK,
        SQ_UP_RATE,
        SQ_UP_HEAD,
        SQ_DN_RATE,
        SQ_HD_END,
        SQ_EMIT
    } t_seq;

    // Operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_SQRT
    } t_uop;

    // Request to the shared unit
    typedef struct packed {
        logic              start;
        t_uop              op;
        logic [63:0]       x;
        logic [63:0]       y;
    } t_ureq;

    // Response from the shared unit
    typedef struct packed {
        logic              done;
        logic [63:0]       quo;
        logic [63:0]       rem;
    } t_ursp;

endpackage

// File: sv/svp_unit.sv
// Shared serial arithmetic unit: shift-and-add multiply, restoring divide, square root.
module svp_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svp_pkg::t_ureq  i_req,
    output svp_pkg::t_ursp  o_rsp
);
    import svp_pkg::*;

    localparam logic [5:0] MUL_LAST  = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd63;
    localparam logic [5:0] SQRT_LAST = 6'd31;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    t_uop        r_op, n_op;
    logic [5:0]  r_cnt, n_cnt;
    logic [64:0] r_acc, n_acc;
    logic [63:0] r_x, n_x;
    logic [63:0] r_y, n_y;
    logic [63:0] r_q, n_q;

    logic [64:0] w_opa, w_opb;
    logic        w_sub;
    logic [65:0] w_sum;
    logic        w_last;

    // Operand selection for the single adder
    always_comb begin
        case (r_op)
            UOP_DIV: begin
                w_opa  = {r_acc[63:0], r_x[63]};
                w_opb  = {1'b0, r_y};
                w_sub  = 1'b1;
                w_last = (r_cnt == DIV_LAST);
            end
            UOP_SQRT: begin
                w_opa  = {r_acc[62:0], r_x[63:62]};
                w_opb  = {1'b0, r_q[61:0], 2'b01};
                w_sub  = 1'b1;
                w_last = (r_cnt == SQRT_LAST);
            end
            default: begin
                w_opa  = r_acc;
                w_opb  = {1'b0, r_x};
                w_sub  = 1'b0;
                w_last = (r_cnt == MUL_LAST);
            end
        endcase
    end

    // The carry out of a subtract says the trial value fits
    assign w_sum = {1'b0, w_opa} + {1'b0, (w_sub ? ~w_opb : w_opb)} + {65'd0, w_sub};

    // One step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = '0;
            n_acc  = '0;
            n_x    = i_req.x;
            n_y    = i_req.y;
            n_q    = '0;
        end else if (r_busy) begin
            case (r_op)
                UOP_DIV: begin
                    n_acc = w_sum[65] ? w_sum[64:0] : w_opa;
                    n_q   = {r_q[62:0], w_sum[65]};
                    n_x   = {r_x[62:0], 1'b0};
                end
                UOP_SQRT: begin
                    n_acc = w_sum[65] ? w_sum[64:0] : w_opa;
                    n_q   = {r_q[62:0], w_sum[65]};
                    n_x   = {r_x[61:0], 2'b00};
                end
                default: begin
                    n_acc = r_y[0] ? w_sum[64:0] : r_acc;
                    n_x   = {r_x[62:0], 1'b0};
                    n_y   = {1'b0, r_y[63:1]};
                end
            endcase
            n_cnt = r_cnt + 6'd1;
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= UOP_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_q   <= n_q;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = (r_op == UOP_MUL) ? r_acc[63:0] : r_q;
    assign o_rsp.rem  = r_acc[63:0];

endmodule

// File: sv/svp_ctrl.sv
// Sequencer, move state and output register of the spin velocity profile generator.
module svp_ctrl #(
    parameter int unsigned STEP_COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [svp_pkg::DT_W-1:0]      i_time_step,
    input  logic [svp_pkg::LIM_W-1:0]     i_max_accel,
    input  logic [svp_pkg::LIM_W-1:0]     i_max_rate,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_in_mode,
    input  logic [svp_pkg::HIN_W-1:0]     i_in_start,
    input  logic [svp_pkg::HIN_W-1:0]     i_in_end,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [svp_pkg::HOUT_W-1:0]    o_out_head,
    output logic [svp_pkg::RATE_W-1:0]    o_out_rate,
    output logic                          o_out_tri,
    output logic                          o_out_last,
    output svp_pkg::t_ureq                o_ureq,
    input  svp_pkg::t_ursp                i_ursp
);
    import svp_pkg::*;

    localparam int unsigned SCB = STEP_COUNT_BITS;
    localparam logic [64:0] STEP_MAX = (65'd1 << SCB) - 65'd1;

    // Saturate a step count
    function automatic logic [SCB-1:0] f_sat(input logic [64:0] v);
        logic [SCB-1:0] res;
        if (v > STEP_MAX) res = STEP_MAX[SCB-1:0];
        else res = v[SCB-1:0];
        return res;
    endfunction

    // Clamp to the 32-bit heading range
    function automatic logic signed [31:0] f_clamp32(input logic signed [48:0] v);
        logic signed [31:0] res;
        if (v[48] && !(&v[47:31])) res = {1'b1, 31'd0};
        else if (!v[48] && (|v[47:31])) res = {1'b0, {31{1'b1}}};
        else res = v[31:0];
        return res;
    endfunction

    // Clamp to the output heading range
    function automatic logic signed [19:0] f_clamp20(input logic signed [31:0] v);
        logic signed [19:0] res;
        if (v[31] && !(&v[30:19])) res = {1'b1, 19'd0};
        else if (!v[31] && (|v[30:19])) res = {1'b0, {19{1'b1}}};
        else res = v[19:0];
        return res;
    endfunction

    function automatic logic [24:0] f_mag25(input logic signed [24:0] v);
        logic [24:0] res;
        if (v[24]) res = 25'(-v);
        else res = v;
        return res;
    endfunction

    t_seq                r_state, n_state;
    t_seq                r_ret, n_ret;
    t_phase              r_phase, n_phase;
    logic signed [18:0]  r_origin, n_origin;
    logic signed [18:0]  r_goal, n_goal;
    logic signed [31:0]  r_head, n_head;
    logic signed [24:0]  r_rate, n_rate;
    logic signed [24:0]  r_accel, n_accel;
    logic [31:0]         r_elapsed, n_elapsed;
    logic [SCB-1:0]      r_ramp, n_ramp;
    logic [SCB-1:0]      r_cruise, n_cruise;
    logic [SCB-1:0]      r_sc, n_sc;
    logic                r_tri, n_tri;
    logic [17:0]         r_p, n_p;
    logic [41:0]         r_pa, n_pa;
    logic [41:0]         r_excess, n_excess;
    logic [63:0]         r_den, n_den;
    logic signed [19:0]  r_em_head, n_em_head;
    logic signed [24:0]  r_em_rate, n_em_rate;
    logic                r_em_last, n_em_last;
    logic                r_o_valid, n_o_valid;
    logic signed [19:0]  r_o_head, n_o_head;
    logic signed [24:0]  r_o_rate, n_o_rate;
    logic                r_o_tri, n_o_tri;
    logic                r_o_last, n_o_last;

    // Start item: wrapped heading difference
    logic signed [19:0]  w_d_raw, w_d;
    logic [17:0]         w_p;
    logic signed [24:0]  w_start_accel;

    assign w_d_raw = $signed({i_in_end[18], i_in_end}) - $signed({i_in_start[18], i_in_start});
    always_comb begin
        if (w_d_raw > PI_Q) w_d = w_d_raw - TWO_PI_Q;
        else if (w_d_raw < -PI_Q) w_d = w_d_raw + TWO_PI_Q;
        else w_d = w_d_raw;
    end
    assign w_p = w_d[19] ? 18'(-w_d) : w_d[17:0];
    always_comb begin
        if (w_d == '0) w_start_accel = '0;
        else if (w_d[19]) w_start_accel = -$signed({1'b0, i_max_accel});
        else w_start_accel = $signed({1'b0, i_max_accel});
    end

    // Rounded unit results
    logic [63:0]         w_rsum16, w_rsum17;
    logic [47:0]         w_r16;
    logic [46:0]         w_r17;
    assign w_rsum16 = i_ursp.quo + 64'h8000;
    assign w_rsum17 = i_ursp.quo + 64'h1_0000;
    assign w_r16    = w_rsum16[63:16];
    assign w_r17    = w_rsum17[63:17];

    logic [24:0]         w_accel_mag, w_rate_mag;
    assign w_accel_mag = f_mag25(r_accel);
    assign w_rate_mag  = f_mag25(r_rate);

    // Ramp up rate, rounded and saturated
    logic [47:0]         w_up_lim;
    logic [24:0]         w_up_mag;
    logic signed [24:0]  w_up_rate;
    assign w_up_lim  = r_accel[24] ? 48'h100_0000 : 48'h0FF_FFFF;
    assign w_up_mag  = (w_r16 > w_up_lim) ? w_up_lim[24:0] : w_r16[24:0];
    assign w_up_rate = r_accel[24] ? -$signed(w_up_mag) : $signed(w_up_mag);

    // Ramp up heading from the origin
    logic signed [48:0]  w_up_sum;
    assign w_up_sum = r_rate[24]
                    ? (49'(r_origin) - $signed({2'b00, w_r17}))
                    : (49'(r_origin) + $signed({2'b00, w_r17}));

    // Ramp down rate
    logic signed [26:0]  w_dn_step, w_dn_diff;
    logic signed [24:0]  w_dn_rate;
    assign w_dn_step = r_accel[24] ? -$signed({1'b0, w_r16[25:0]}) : $signed({1'b0, w_r16[25:0]});
    assign w_dn_diff = 27'(r_rate) - w_dn_step;
    always_comb begin
        if (w_dn_diff[26] && !(&w_dn_diff[25:24])) w_dn_rate = RATE_MIN;
        else if (!w_dn_diff[26] && (|w_dn_diff[25:24])) w_dn_rate = RATE_MAX;
        else w_dn_rate = w_dn_diff[24:0];
    end

    // Euler heading step
    logic signed [48:0]  w_hd_sum;
    assign w_hd_sum = r_rate[24]
                    ? (49'(r_head) - $signed({23'd0, w_r16[25:0]}))
                    : (49'(r_head) + $signed({23'd0, w_r16[25:0]}));

    logic signed [31:0]  w_up_head, w_hd_head;
    assign w_up_head = f_clamp32(w_up_sum);
    assign w_hd_head = f_clamp32(w_hd_sum);

    // Elapsed time, saturating
    logic [32:0]         w_t_sum;
    logic [31:0]         w_t;
    assign w_t_sum = {1'b0, r_elapsed} + {17'd0, i_time_step};
    assign w_t     = w_t_sum[32] ? {32{1'b1}} : w_t_sum[31:0];

    // Rounded divide results
    logic                w_round_up;
    logic [32:0]         w_root_half;
    assign w_round_up  = ({i_ursp.rem, 1'b0} >= {1'b0, r_den});
    assign w_root_half = ({1'b0, i_ursp.quo[31:0]} + 33'd1) >> 1;

    logic [63:0]         w_ww;
    assign w_ww = i_ursp.quo;

    logic                w_accept;
    assign w_accept = i_in_valid && (r_state == SQ_IDLE);

    // Sequencer and datapath control
    always_comb begin
        t_phase           v_phase;
        logic [SCB-1:0]   v_sc;
        logic signed [24:0] v_rate;

        n_state   = r_state;
        n_ret     = r_ret;
        n_phase   = r_phase;
        n_origin  = r_origin;
        n_goal    = r_goal;
        n_head    = r_head;
        n_rate    = r_rate;
        n_accel   = r_accel;
        n_elapsed = r_elapsed;
        n_ramp    = r_ramp;
        n_cruise  = r_cruise;
        n_sc      = r_sc;
        n_tri     = r_tri;
        n_p       = r_p;
        n_pa      = r_pa;
        n_excess  = r_excess;
        n_den     = r_den;
        n_em_head = r_em_head;
        n_em_rate = r_em_rate;
        n_em_last = r_em_last;
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_head  = r_o_head;
        n_o_rate  = r_o_rate;
        n_o_tri   = r_o_tri;
        n_o_last  = r_o_last;
        o_ureq    = '{start: 1'b0, op: UOP_MUL, x: '0, y: '0};

        // Phase changes due at the start of a tick
        v_phase = r_phase;
        v_sc    = r_sc;
        v_rate  = r_rate;
        if (v_phase == PH_UP && v_sc >= r_ramp) begin
            v_sc = '0;
            if (r_tri) begin
                v_phase = PH_DOWN;
            end else begin
                v_phase = PH_CRUISE;
                if (r_accel > 0) v_rate = $signed({1'b0, i_max_rate});
                else if (r_accel < 0) v_rate = -$signed({1'b0, i_max_rate});
                else v_rate = '0;
            end
        end
        if (v_phase == PH_CRUISE && v_sc >= r_cruise) begin
            v_sc    = '0;
            v_phase = PH_DOWN;
        end
        if (v_phase == PH_DOWN && v_sc >= r_ramp) v_phase = PH_FINAL;

        case (r_state)
            SQ_IDLE: begin
                if (w_accept) begin
                    if (i_in_mode == MODE_START) begin
                        n_origin  = $signed(i_in_start);
                        n_goal    = $signed(i_in_end);
                        n_head    = 32'($signed(i_in_start));
                        n_rate    = '0;
                        n_elapsed = '0;
                        n_sc      = '0;
                        n_cruise  = '0;
                        n_accel   = w_start_accel;
                        n_p       = w_p;
                        n_state   = SQ_PA;
                    end else if (r_phase != PH_IDLE) begin
                        n_phase = v_phase;
                        n_sc    = v_sc;
                        n_rate  = v_rate;
                        n_state = SQ_TICK;
                    end
                end
            end
            SQ_WAIT: begin
                if (i_ursp.done) n_state = r_ret;
            end
            SQ_PA: begin
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(i_max_accel), y: 64'(r_p)};
                n_ret   = SQ_WW;
                n_state = SQ_WAIT;
            end
            SQ_WW: begin
                n_pa    = i_ursp.quo[41:0];
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(i_max_rate), y: 64'(i_max_rate)};
                n_ret   = SQ_PICK;
                n_state = SQ_WAIT;
            end
            SQ_PICK: begin
                n_excess = r_pa - w_ww[41:0];
                if (64'(r_pa) < w_ww) begin
                    n_tri   = 1'b1;
                    n_state = SQ_T_ADT;
                end else begin
                    n_tri   = 1'b0;
                    n_state = SQ_R_ADT;
                end
            end
            SQ_T_ADT: begin
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(i_max_accel), y: 64'(i_time_step)};
                n_ret   = SQ_T_DEN;
                n_state = SQ_WAIT;
            end
            SQ_T_DEN: begin
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(i_ursp.quo[39:0]),
                            y: 64'(i_time_step)};
                n_ret   = SQ_T_DIV;
                n_state = SQ_WAIT;
            end
            SQ_T_DIV: begin
                if (i_ursp.quo == '0) begin
                    n_ramp  = STEP_MAX[SCB-1:0];
                    n_phase = PH_REST;
                    n_state = SQ_IDLE;
                end else begin
                    o_ureq  = '{start: 1'b1, op: UOP_DIV, x: {12'd0, r_p, 34'd0}, y: i_ursp.quo};
                    n_ret   = SQ_T_SQRT;
                    n_state = SQ_WAIT;
                end
            end
            SQ_T_SQRT: begin
                o_ureq  = '{start: 1'b1, op: UOP_SQRT, x: i_ursp.quo, y: '0};
                n_ret   = SQ_T_END;
                n_state = SQ_WAIT;
            end
            SQ_T_END: begin
                n_ramp  = f_sat(65'(w_root_half));
                n_phase = PH_REST;
                n_state = SQ_IDLE;
            end
            SQ_R_ADT: begin
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(i_max_accel), y: 64'(i_time_step)};
                n_ret   = SQ_R_DIV;
                n_state = SQ_WAIT;
            end
            SQ_R_DIV: begin
                n_den = i_ursp.quo;
                if (i_ursp.quo == '0) begin
                    n_ramp  = STEP_MAX[SCB-1:0];
                    n_state = SQ_R_AW;
                end else begin
                    o_ureq  = '{start: 1'b1, op: UOP_DIV, x: {24'd0, i_max_rate, 16'd0},
                                y: i_ursp.quo};
                    n_ret   = SQ_R_RND;
                    n_state = SQ_WAIT;
                end
            end
            SQ_R_RND: begin
                n_ramp  = f_sat({1'b0, i_ursp.quo} + 65'(w_round_up));
                n_state = SQ_R_AW;
            end
            SQ_R_AW: begin
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(i_max_accel), y: 64'(i_max_rate)};
                n_ret   = SQ_R_AWDT;
                n_state = SQ_WAIT;
            end
            SQ_R_AWDT: begin
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(i_ursp.quo[47:0]),
                            y: 64'(i_time_step)};
                n_ret   = SQ_R_CDIV;
                n_state = SQ_WAIT;
            end
            SQ_R_CDIV: begin
                n_den = i_ursp.quo;
                if (i_ursp.quo == '0) begin
                    n_cruise = STEP_MAX[SCB-1:0];
                    n_phase  = PH_UP;
                    n_state  = SQ_IDLE;
                end else begin
                    o_ureq  = '{start: 1'b1, op: UOP_DIV, x: {6'd0, r_excess, 16'd0},
                                y: i_ursp.quo};
                    n_ret   = SQ_R_END;
                    n_state = SQ_WAIT;
                end
            end
            SQ_R_END: begin
                n_cruise = f_sat({1'b0, i_ursp.quo} + 65'(w_round_up));
                n_phase  = PH_UP;
                n_state  = SQ_IDLE;
            end
            SQ_TICK: begin
                case (r_phase)
                    PH_REST: begin
                        n_em_head = 20'(r_origin);
                        n_em_rate = '0;
                        n_em_last = 1'b0;
                        n_phase   = PH_UP;
                        n_sc      = '0;
                        n_state   = SQ_EMIT;
                    end
                    PH_FINAL: begin
                        n_em_head = 20'(r_goal);
                        n_em_rate = '0;
                        n_em_last = 1'b1;
                        n_phase   = PH_IDLE;
                        n_state   = SQ_EMIT;
                    end
                    PH_UP: begin
                        n_elapsed = w_t;
                        o_ureq    = '{start: 1'b1, op: UOP_MUL, x: 64'(w_accel_mag), y: 64'(w_t)};
                        n_ret     = SQ_UP_RATE;
                        n_state   = SQ_WAIT;
                    end
                    PH_CRUISE: begin
                        o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(w_rate_mag),
                                    y: 64'(i_time_step)};
                        n_ret   = SQ_HD_END;
                        n_state = SQ_WAIT;
                    end
                    PH_DOWN: begin
                        o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(w_accel_mag),
                                    y: 64'(i_time_step)};
                        n_ret   = SQ_DN_RATE;
                        n_state = SQ_WAIT;
                    end
                    default: begin
                        n_state = SQ_IDLE;
                    end
                endcase
            end
            SQ_UP_RATE: begin
                n_rate  = w_up_rate;
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(f_mag25(w_up_rate)),
                            y: 64'(r_elapsed)};
                n_ret   = SQ_UP_HEAD;
                n_state = SQ_WAIT;
            end
            SQ_UP_HEAD: begin
                n_head    = w_up_head;
                n_sc      = r_sc + 1'b1;
                n_em_head = f_clamp20(w_up_head);
                n_em_rate = r_rate;
                n_em_last = 1'b0;
                n_state   = SQ_EMIT;
            end
            SQ_DN_RATE: begin
                n_rate  = w_dn_rate;
                o_ureq  = '{start: 1'b1, op: UOP_MUL, x: 64'(f_mag25(w_dn_rate)),
                            y: 64'(i_time_step)};
                n_ret   = SQ_HD_END;
                n_state = SQ_WAIT;
            end
            SQ_HD_END: begin
                n_head    = w_hd_head;
                n_sc      = r_sc + 1'b1;
                n_em_head = f_clamp20(w_hd_head);
                n_em_rate = r_rate;
                n_em_last = 1'b0;
                n_state   = SQ_EMIT;
            end
            SQ_EMIT: begin
                // Wait for room in the output register
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid = 1'b1;
                    n_o_head  = r_em_head;
                    n_o_rate  = r_em_rate;
                    n_o_tri   = r_tri;
                    n_o_last  = r_em_last;
                    n_state   = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SQ_IDLE;
            r_ret     <= SQ_IDLE;
            r_phase   <= PH_IDLE;
            r_origin  <= '0;
            r_goal    <= '0;
            r_head    <= '0;
            r_rate    <= '0;
            r_accel   <= '0;
            r_elapsed <= '0;
            r_ramp    <= '0;
            r_cruise  <= '0;
            r_sc      <= '0;
            r_tri     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_phase   <= n_phase;
            r_origin  <= n_origin;
            r_goal    <= n_goal;
            r_head    <= n_head;
            r_rate    <= n_rate;
            r_accel   <= n_accel;
            r_elapsed <= n_elapsed;
            r_ramp    <= n_ramp;
            r_cruise  <= n_cruise;
            r_sc      <= n_sc;
            r_tri     <= n_tri;
            r_o_valid <= n_o_valid;
        end
        r_p       <= n_p;
        r_pa      <= n_pa;
        r_excess  <= n_excess;
        r_den     <= n_den;
        r_em_head <= n_em_head;
        r_em_rate <= n_em_rate;
        r_em_last <= n_em_last;
        r_o_head  <= n_o_head;
        r_o_rate  <= n_o_rate;
        r_o_tri   <= n_o_tri;
        r_o_last  <= n_o_last;
    end

    assign o_in_ready  = (r_state == SQ_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_head  = r_o_head;
    assign o_out_rate  = r_o_rate;
    assign o_out_tri   = r_o_tri;
    assign o_out_last  = r_o_last;

endmodule

// File: sv/spin_velocity_profile.sv
// Spin-in-place angular rate profile generator, top level with configuration registers.
//
// A start item (tuser low) sets up a triangular or trapezoidal move and produces no
// result; each tick item (tuser high) produces one heading and rate setpoint while a
// move runs, the last one flagged on tlast. All multiplies, divides and square roots run
// through one shared serial unit that retires one bit per cycle. The input is not ready
// while an item is at work, including any wait for the output register to drain.
module spin_velocity_profile #(
    parameter int unsigned STEP_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // start_heading[18:0], end_heading[37:19], zero pad
    input  logic [0:0]  s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // heading_setpoint[19:0], rate_setpoint[44:20], pad
    output logic [0:0]  m_axis_tuser,   // triangular[0]
    output logic        m_axis_tlast
);
    import svp_pkg::*;

    logic [DT_W-1:0]  r_time_step;
    logic [LIM_W-1:0] r_max_accel;
    logic [LIM_W-1:0] r_max_rate;

    t_ureq            w_ureq;
    t_ursp            w_ursp;
    logic [HOUT_W-1:0] w_head;
    logic [RATE_W-1:0] w_rate;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= 16'd1311;
            r_max_accel <= 24'd13107;
            r_max_rate  <= 24'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIME_STEP: r_time_step <= i_cfg_data[15:0];
                CFG_MAX_ACCEL: r_max_accel <= i_cfg_data;
                CFG_MAX_RATE:  r_max_rate  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    svp_ctrl #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_time_step (r_time_step),
        .i_max_accel (r_max_accel),
        .i_max_rate  (r_max_rate),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_mode   (s_axis_tuser[0]),
        .i_in_start  (s_axis_tdata[18:0]),
        .i_in_end    (s_axis_tdata[37:19]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_head  (w_head),
        .o_out_rate  (w_rate),
        .o_out_tri   (m_axis_tuser[0]),
        .o_out_last  (m_axis_tlast),
        .o_ureq      (w_ureq),
        .i_ursp      (w_ursp)
    );

    svp_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ureq),
        .o_rsp   (w_ursp)
    );

    assign m_axis_tdata = {3'd0, w_rate, w_head};

endmodule

// File: tb/tb.sv
// Self-checking testbench for the spin velocity profile generator.
`timescale 1ns / 1ps

module tb;
    import svp_pkg::*;

    localparam int unsigned STEPS_MAX = 65535;
    localparam longint HEADING_LIMIT_HI = 524287;
    localparam longint HEADING_LIMIT_LO = -524288;
    localparam longint RATE_LIMIT_HI = 16777215;
    localparam longint RATE_LIMIT_LO = -16777216;
    localparam longint ANGLE_PI = 205887;
    localparam longint ANGLE_TWO_PI = 411775;
    localparam longint HOLD_MAX = 2147483647;
    localparam longint HOLD_MIN = -64'sd2147483648;
    localparam logic MODE_TICK = 1'b1;

    // One expected setpoint
    typedef struct {
        logic signed [19:0] heading;
        logic signed [24:0] rate;
        logic               tri_flag;
        logic               last;
    } setpoint_t;

    // One row of the directed table
    typedef struct {
        logic               mode;
        logic signed [18:0] start_hd;
        logic signed [18:0] end_hd;
        logic               typed;
        setpoint_t          sp;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    spin_velocity_profile dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor copy of configuration and move state
    longint dt_q, accel_q, rate_lim_q;
    t_phase ph;
    longint origin_q, goal_q, head_q, rate_q, accel_s;
    longint elapsed_q, ramp_n, cruise_n, step_n;
    logic   tri_q;

    setpoint_t pending_sp[$];
    setpoint_t last_pred;
    realtime   pred_at = -1.0;
    int        stall_left = 0;
    int        n_errors = 0;
    bit        quiet = 1'b0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_shift(longint v, int sh);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint count_sat(longint n);
        return n > STEPS_MAX ? STEPS_MAX : n;
    endfunction

    function automatic longint div_nearest(longint num, longint den);
        longint q, r;
        if (den == 0) return STEPS_MAX + 1;
        q = num / den;
        r = num % den;
        if (r >= den - r) q++;
        return q;
    endfunction

    function automatic longint int_sqrt(longint x);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    task automatic reset_model();
        dt_q = 1311; accel_q = 13107; rate_lim_q = 65536;
        ph = PH_IDLE;
        origin_q = 0; goal_q = 0; head_q = 0; rate_q = 0; accel_s = 0;
        elapsed_q = 0; ramp_n = 0; cruise_n = 0; step_n = 0; tri_q = 1'b0;
    endtask

    // Latch a new move and plan its profile
    task automatic plan_move(logic signed [18:0] s, logic signed [18:0] e);
        longint d, p, sg, den;
        origin_q = s;
        goal_q = e;
        d = goal_q - origin_q;
        while (d > ANGLE_PI) d -= ANGLE_TWO_PI;
        while (d < -ANGLE_PI) d += ANGLE_TWO_PI;
        sg = d > 0 ? 1 : (d < 0 ? -1 : 0);
        p = d < 0 ? -d : d;
        accel_s = sg * accel_q;
        head_q = origin_q; rate_q = 0; elapsed_q = 0; step_n = 0; cruise_n = 0;
        if (p * accel_q < rate_lim_q * rate_lim_q) begin
            tri_q = 1'b1;
            den = accel_q * dt_q * dt_q;
            if (den == 0) ramp_n = STEPS_MAX;
            else ramp_n = count_sat((int_sqrt((p <<< 34) / den) + 1) >>> 1);
            ph = PH_REST;
        end else begin
            tri_q = 1'b0;
            ramp_n = count_sat(div_nearest(rate_lim_q <<< 16, accel_q * dt_q));
            cruise_n = count_sat(div_nearest((p * accel_q - rate_lim_q * rate_lim_q) <<< 16,
                                             accel_q * rate_lim_q * dt_q));
            ph = PH_UP;
        end
    endtask

    // Advance one tick; returns 1 and the setpoint when one is produced
    function automatic bit tick_setpoint(output setpoint_t sp);
        longint t, mag, hd, rt;
        bit fin;
        fin = 1'b0;
        if (ph == PH_IDLE) return 1'b0;
        if (ph == PH_UP && step_n >= ramp_n) begin
            step_n = 0;
            if (tri_q) ph = PH_DOWN;
            else begin
                ph = PH_CRUISE;
                rate_q = accel_s > 0 ? rate_lim_q : (accel_s < 0 ? -rate_lim_q : 0);
            end
        end
        if (ph == PH_CRUISE && step_n >= cruise_n) begin
            step_n = 0;
            ph = PH_DOWN;
        end
        if (ph == PH_DOWN && step_n >= ramp_n) ph = PH_FINAL;
        if (ph == PH_REST) begin
            hd = origin_q; rt = 0; ph = PH_UP; step_n = 0;
        end else if (ph == PH_FINAL) begin
            hd = goal_q; rt = 0; fin = 1'b1; ph = PH_IDLE;
        end else begin
            if (ph == PH_UP) begin
                t = elapsed_q + dt_q;
                if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
                elapsed_q = t;
                rate_q = clip(round_shift(accel_s * t, 16), RATE_LIMIT_LO, RATE_LIMIT_HI);
                mag = round_shift((rate_q < 0 ? -rate_q : rate_q) * t, 17);
                head_q = clip(origin_q + (rate_q < 0 ? -mag : mag), HOLD_MIN, HOLD_MAX);
            end else begin
                if (ph == PH_DOWN)
                    rate_q = clip(rate_q - round_shift(accel_s * dt_q, 16),
                                  RATE_LIMIT_LO, RATE_LIMIT_HI);
                head_q = clip(head_q + round_shift(rate_q * dt_q, 16), HOLD_MIN, HOLD_MAX);
            end
            step_n++;
            hd = head_q; rt = rate_q;
        end
        sp.heading = 20'(clip(hd, HEADING_LIMIT_LO, HEADING_LIMIT_HI));
        sp.rate = 25'(rt);
        sp.tri_flag = tri_q;
        sp.last = fin;
        return 1'b1;
    endfunction

    task automatic report(string what);
        n_errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Queue one expected setpoint and remember it for the typed rows
    task automatic queue_expected(setpoint_t sp);
        pending_sp.insert(pending_sp.size(), sp);
        last_pred = sp;
        pred_at = $realtime;
    endtask

    // Sender: one item, with optional idle burst before it
    task automatic send_item(logic mode, logic signed [18:0] s, logic signed [18:0] e);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, e, s};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Predict on acceptance
    always @(posedge i_clk) begin
        setpoint_t sp;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (s_axis_tuser[0] == MODE_START)
                plan_move(s_axis_tdata[18:0], s_axis_tdata[37:19]);
            else if (tick_setpoint(sp))
                queue_expected(sp);
        end
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIME_STEP: dt_q = i_cfg_data[15:0];
                CFG_MAX_ACCEL: accel_q = i_cfg_data;
                CFG_MAX_RATE:  rate_lim_q = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Receiver: stalls in bursts, compare each setpoint with the oldest expected one
    always @(posedge i_clk) begin
        setpoint_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_sp.size() == 0) begin
                    report("setpoint with nothing expected");
                end else begin
                    want = pending_sp.pop_front();
                    if (m_axis_tdata[19:0] !== want.heading)
                        report($sformatf("heading %0d want %0d",
                               $signed(m_axis_tdata[19:0]), want.heading));
                    if (m_axis_tdata[44:20] !== want.rate)
                        report($sformatf("rate %0d want %0d",
                               $signed(m_axis_tdata[44:20]), want.rate));
                    if (m_axis_tuser[0] !== want.tri_flag) report("triangular flag");
                    if (m_axis_tlast !== want.last) report("last flag");
                end
            end
            if (quiet) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Let the block finish and drain before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_sp.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    function automatic logic signed [18:0] rand_heading();
        return 19'($urandom_range(0, 411775) - 205888);
    endfunction

    // Run moves, some cut short, with random content and some noise
    task automatic random_moves(int n_items);
        int sent, k, n_ticks;
        sent = 0;
        while (sent < n_items) begin
            send_item(MODE_START, rand_heading(), rand_heading());
            sent++;
            n_ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 40;
            for (k = 0; k < n_ticks && sent < n_items; k++) begin
                send_item(MODE_TICK, 19'($urandom), 19'($urandom));
                sent++;
                if (ph == PH_IDLE && $urandom_range(0, 1) == 0) break;
            end
        end
    endtask

    row_t dir_rows[$];

    initial begin
        row_t r;
        int i;
        realtime t_acc;
        setpoint_t none;
        none = '{0, 0, 0, 0};
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: idle tick, zero move, extremes, restart mid-move
        dir_rows = '{
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none},
            '{MODE_START, 19'sd1000, 19'sd1000, 1'b0, none},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b1, '{20'sd1000, 25'sd0, 1'b1, 1'b0}},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b1, '{20'sd1000, 25'sd0, 1'b1, 1'b1}},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none},
            '{MODE_START, -19'sd205888, 19'sd205887, 1'b0, none},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none},
            '{MODE_START, 19'sd205887, -19'sd205888, 1'b0, none},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none},
            '{MODE_TICK, -19'sd1, -19'sd1, 1'b0, none},
            '{MODE_START, -19'sd1, 19'sd0, 1'b0, none},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none},
            '{MODE_START, 19'sd0, 19'sd150000, 1'b0, none},
            '{MODE_TICK, 19'sd0, 19'sd0, 1'b0, none}
        };
        for (i = 0; i < dir_rows.size(); i++) begin
            r = dir_rows[i];
            send_item(r.mode, r.start_hd, r.end_hd);
            t_acc = $realtime;
            // Typed rows check the predictor against the obvious value
            if (r.typed) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                if (pred_at != t_acc)
                    report($sformatf("row %0d gave no setpoint", i));
                else if (last_pred.heading !== r.sp.heading || last_pred.rate !== r.sp.rate ||
                         last_pred.tri_flag !== r.sp.tri_flag ||
                         last_pred.last !== r.sp.last)
                    report($sformatf("row %0d setpoint differs from its typed value", i));
                while (pending_sp.size() != 0) @(posedge i_clk);
            end
        end
        drain();

        // Settings sweep, extremes included; large steps keep some moves short
        random_moves(300);
        drain();
        write_reg(CFG_TIME_STEP, 24'd65535);
        write_reg(CFG_MAX_ACCEL, 24'd16777215);
        write_reg(CFG_MAX_RATE, 24'd16777215);
        random_moves(200);
        drain();
        write_reg(CFG_TIME_STEP, 24'd30000);
        write_reg(CFG_MAX_ACCEL, 24'd1);
        write_reg(CFG_MAX_RATE, 24'd1);
        random_moves(150);
        drain();
        write_reg(CFG_TIME_STEP, 24'd20000);
        write_reg(CFG_MAX_ACCEL, 24'd200000);
        write_reg(CFG_MAX_RATE, 24'd1);
        random_moves(150);
        drain();
        write_reg(CFG_TIME_STEP, 24'd8000);
        write_reg(CFG_MAX_ACCEL, 24'd400000);
        write_reg(CFG_MAX_RATE, 24'd300000);
        random_moves(250);
        drain();
        write_reg(CFG_TIME_STEP, 24'd1);
        write_reg(CFG_MAX_ACCEL, 24'd16777215);
        write_reg(CFG_MAX_RATE, 24'd16777215);
        random_moves(60);
        drain();
        write_reg(CFG_TIME_STEP, 24'd12000);
        write_reg(CFG_MAX_ACCEL, 24'd300000);
        write_reg(CFG_MAX_RATE, 24'd200000);
        quiet = 1'b1;
        random_moves(120);
        drain();

        if (n_errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        #200ms;
        $display("FAILURE");
        $finish;
    end
endmodule
